>>> hw/rtl/pds_pkg.sv
package pds_pkg;
   localparam int MapWidthDefault  = 256;
   localparam int MapHeightDefault = 256;
   localparam int MaxRadiusDefault = 4;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 17;

   localparam logic [CsrIndexW-1:0] CSR_WIDTH  = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_HEIGHT = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_PHGT   = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_THRESH = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_RADIUS = 3'd4;
   localparam logic [CsrIndexW-1:0] CSR_MOVES  = 3'd5;

   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_DROP = 2'd1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  pos_x;
      logic [7:0]  pos_y;
      logic [15:0] cell_value;
   } req_type;

   typedef struct packed {
      logic [7:0]  final_x;
      logic [7:0]  final_y;
      logic [15:0] final_height;
      logic        placed;
      logic [9:0]  move_total;
      logic        touched;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // latch request, set center
      logic own_latch;  // latch own height
      logic scan_init;  // reset ring scan to r=1 start
      logic rd_cand;    // read candidate cell
      logic cand_eval;  // evaluate candidate read data
      logic scan_next;  // advance scan position
      logic move;       // move center to found candidate
      logic write_cell; // write height/activity at center
      logic load_rsp;   // build response
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_drop;
      logic is_load;
      logic in_bounds;
      logic cand_valid; // current scan position is a usable candidate
      logic hit;        // evaluated candidate meets threshold
      logic scan_done;  // current position is the last one to visit, or no ring to scan
      logic moves_left;
      logic clearing;   // activity map clear after reset still running
   } sts_type;
endpackage

>>> hw/rtl/pds_stream_if.sv
interface pds_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/pds_datapath.sv
module pds_datapath import pds_pkg::*; #(
   parameter int MAP_WIDTH  = MapWidthDefault,
   parameter int MAP_HEIGHT = MapHeightDefault,
   parameter int MAX_RADIUS = MaxRadiusDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_data,
   input  req_type              req_data,
   input  cmd_type              cmd,
   output sts_type              sts,
   output rsp_type              rsp_data
);
   localparam int XW    = $clog2(MAP_WIDTH);
   localparam int YW    = $clog2(MAP_HEIGHT);
   localparam int Cells = MAP_WIDTH * MAP_HEIGHT;
   localparam int AW    = $clog2(Cells);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int CW    = 11; // signed coordinate, covers -8..263
   localparam int LimW  = (MAP_WIDTH < 256) ? MAP_WIDTH : 256;
   localparam int LimH  = (MAP_HEIGHT < 256) ? MAP_HEIGHT : 256;

   logic [8:0]  width_ff, height_ff;
   logic [15:0] phgt_ff;
   logic [16:0] thresh_ff;
   logic [2:0]  radius_ff;
   logic [9:0]  maxmv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         phgt_ff   <= 16'd82;
         thresh_ff <= 17'd164;
         radius_ff <= 3'd1;
         maxmv_ff  <= 10'd1000;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data[8:0];
            CSR_HEIGHT: height_ff <= csr_data[8:0];
            CSR_PHGT:   phgt_ff   <= csr_data[15:0];
            CSR_THRESH: thresh_ff <= csr_data;
            CSR_RADIUS: radius_ff <= csr_data[2:0];
            CSR_MOVES:  maxmv_ff  <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   logic [8:0] lim_w, lim_h;
   assign lim_w = (width_ff > 9'(LimW)) ? 9'(LimW) : width_ff;
   assign lim_h = (height_ff > 9'(LimH)) ? 9'(LimH) : height_ff;

   logic [RW-1:0] rmax;
   assign rmax = (int'(radius_ff) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_ff);

   // memories
   logic [15:0] hmem [Cells];
   logic        amem [Cells];
   logic [15:0] hrd_ff;
   logic        ard_ff;

   req_type       req_ff;
   logic [7:0]    cx_ff, cy_ff;
   logic [15:0]   own_ff;
   logic [9:0]    moves_ff;
   logic [RW-1:0] r_ff;
   logic signed [RW+1:0] dx_ff, dy_ff;
   logic [7:0]    candx_ff, candy_ff;

   logic signed [CW-1:0] sx, sy;
   assign sx = CW'(signed'({1'b0, cx_ff})) + CW'(dx_ff);
   assign sy = CW'(signed'({1'b0, cy_ff})) + CW'(dy_ff);

   logic signed [2*RW+3:0] dxw, dyw;
   assign dxw = (2*RW+4)'(dx_ff);
   assign dyw = (2*RW+4)'(dy_ff);

   logic [2*RW+3:0] d2, r2;
   assign d2 = $unsigned(dxw * dxw + dyw * dyw);
   assign r2 = (2*RW+4)'(r_ff) * (2*RW+4)'(r_ff);

   logic sx_in, sy_in;
   assign sx_in = !sx[CW-1] && (sx < CW'(signed'({2'b0, lim_w})));
   assign sy_in = !sy[CW-1] && (sy < CW'(signed'({2'b0, lim_h})));

   logic last_pos;
   assign last_pos = (r_ff == rmax) && (dx_ff == (RW+2)'(r_ff)) &&
                     (dy_ff == (RW+2)'(r_ff));

   function automatic logic [AW-1:0] addr_of(input logic [7:0] x, input logic [7:0] y);
      logic [AW-1:0] a;
      a = AW'(YW'(y)) * AW'(MAP_WIDTH) + AW'(XW'(x));
      return a;
   endfunction

   logic [AW-1:0] addr;
   always_comb begin
      if (cmd.rd_cand) addr = addr_of(sx[7:0], sy[7:0]);
      else             addr = addr_of(cx_ff, cy_ff);
   end

   logic [16:0] sum;
   assign sum = 17'(own_ff) + 17'(phgt_ff);
   logic [15:0] dep;
   assign dep = sum[16] ? 16'hFFFF : sum[15:0];

   always_ff @(posedge clock) begin
      if (cmd.write_cell) begin
         if (req_ff.kind == KIND_DROP) hmem[addr] <= dep;
         else                          hmem[addr] <= req_ff.cell_value;
      end
      hrd_ff <= hmem[addr];
   end

   // clear the activity map after reset, one cell per cycle
   logic [AW-1:0] clr_ff;
   logic          clr_busy_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clr_busy_ff <= 1'b1;
      end else if (clr_busy_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == AW'(Cells - 1)) clr_busy_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (clr_busy_ff) amem[clr_ff] <= 1'b0;
      else if (cmd.write_cell && req_ff.kind == KIND_DROP) amem[addr] <= 1'b1;
      ard_ff <= amem[addr];
   end

   logic hit_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff   <= req_data;
         cx_ff    <= req_data.pos_x;
         cy_ff    <= req_data.pos_y;
         moves_ff <= '0;
      end
      if (cmd.own_latch) own_ff <= hrd_ff;
      if (cmd.scan_init) begin
         r_ff  <= RW'(1);
         dx_ff <= -(RW+2)'(1);
         dy_ff <= -(RW+2)'(1);
      end else if (cmd.scan_next) begin
         if (dy_ff != (RW+2)'(r_ff)) dy_ff <= dy_ff + 1'b1;
         else if (dx_ff != (RW+2)'(r_ff)) begin
            dx_ff <= dx_ff + 1'b1;
            dy_ff <= -(RW+2)'(r_ff);
         end else begin
            r_ff  <= r_ff + 1'b1;
            dx_ff <= -(RW+2)'(r_ff + 1'b1);
            dy_ff <= -(RW+2)'(r_ff + 1'b1);
         end
      end
      if (cmd.rd_cand) begin
         candx_ff <= sx[7:0];
         candy_ff <= sy[7:0];
      end
      if (cmd.cand_eval) hit_ff <= 18'(sum) >= 18'(thresh_ff) + 18'(hrd_ff);
      if (cmd.move) begin
         cx_ff    <= candx_ff;
         cy_ff    <= candy_ff;
         moves_ff <= moves_ff + 1'b1;
      end
      if (cmd.load_rsp) begin
         rsp_data.final_x <= cx_ff;
         rsp_data.final_y <= cy_ff;
         rsp_data.placed  <= 1'b0;
         rsp_data.move_total <= '0;
         rsp_data.final_height <= '0;
         rsp_data.touched <= 1'b0;
         if (sts.in_bounds) begin
            if (req_ff.kind == KIND_DROP) begin
               rsp_data.final_height <= dep;
               rsp_data.placed <= 1'b1;
               rsp_data.move_total <= moves_ff;
               rsp_data.touched <= 1'b1;
            end else begin
               rsp_data.final_height <= (req_ff.kind == KIND_LOAD) ?
                                        req_ff.cell_value : hrd_ff;
               rsp_data.touched <= ard_ff;
            end
         end
      end
   end

   logic center;
   assign center = (dx_ff == '0) && (dy_ff == '0);
   assign sts.is_drop    = req_ff.kind == KIND_DROP;
   assign sts.is_load    = req_ff.kind == KIND_LOAD;
   assign sts.in_bounds  = (9'(cx_ff) < lim_w) && (9'(cy_ff) < lim_h);
   assign sts.cand_valid = !center && sx_in && sy_in && (d2 <= r2) && (rmax != '0);
   assign sts.hit        = hit_ff;
   assign sts.scan_done  = last_pos || (rmax == '0);
   assign sts.moves_left = moves_ff < maxmv_ff;
   assign sts.clearing   = clr_busy_ff;
endmodule

>>> hw/rtl/pds_ctrl.sv
module pds_ctrl import pds_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_fire,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    req_ready,
   output logic    rsp_valid
);
   typedef enum logic [3:0] {
      IDLE, CTR, CTR_WAIT, OWN, SCAN, CAND_WAIT, DECIDE, FINISH, RESP, OUT
   } state_type;
   state_type state_ff;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            IDLE:     if (req_fire) state_ff <= CTR;
            CTR:      state_ff <= CTR_WAIT;
            CTR_WAIT: state_ff <= OWN;
            OWN: begin
               if (!sts.in_bounds) state_ff <= RESP;
               else if (sts.is_drop && sts.moves_left) state_ff <= SCAN;
               else state_ff <= FINISH;
            end
            SCAN: begin
               if (sts.cand_valid) state_ff <= CAND_WAIT;
               else if (sts.scan_done) state_ff <= FINISH;
            end
            CAND_WAIT: state_ff <= DECIDE;
            DECIDE: begin
               if (sts.hit) state_ff <= CTR;
               else if (sts.scan_done) state_ff <= FINISH;
               else state_ff <= SCAN;
            end
            FINISH: state_ff <= RESP;
            // hold until the previous result is gone
            RESP:   if (!rsp_valid_ff || rsp_ready) state_ff <= OUT;
            OUT:    state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         IDLE:     cmd.capture = req_fire;
         OWN: begin
            cmd.own_latch = 1'b1;
            cmd.scan_init = 1'b1;
         end
         SCAN: begin
            cmd.rd_cand   = sts.cand_valid;
            cmd.scan_next = !sts.cand_valid && !sts.scan_done;
         end
         CAND_WAIT: cmd.cand_eval = 1'b1;
         DECIDE: begin
            cmd.move      = sts.hit;
            cmd.scan_next = !sts.hit && !sts.scan_done;
         end
         FINISH: cmd.write_cell = !sts.is_drop ? sts.is_load : 1'b1;
         RESP:   cmd.load_rsp = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign req_ready = (state_ff == IDLE) && !sts.clearing;
   assign rsp_valid = rsp_valid_ff;
endmodule

>>> hw/rtl/particle_deposition_settle_core.sv
// Particle settling engine over a heightmap in on-chip memory. One request is in
// work at a time. A load or read fetches and latches the center height, writes
// the cell for a load in bounds, and then builds the response. A drop adds its
// search: ring positions that are not candidates are stepped past, each candidate
// cell is read and evaluated (one memory port, registered read data), and each
// move fetches the new center height; ring r visits (2r+1)^2 positions. A result
// that is not taken holds the block before it loads the next one. After reset the
// activity map is cleared one cell per cycle; requests wait.
module particle_deposition_settle_core import pds_pkg::*; #(
   parameter int MAP_WIDTH  = MapWidthDefault,
   parameter int MAP_HEIGHT = MapHeightDefault,
   parameter int MAX_RADIUS = MaxRadiusDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_data,
   pds_stream_if.sink           req,
   pds_stream_if.source         rsp
);
   cmd_type cmd;
   sts_type sts;
   logic    rdy;
   logic    fire;
   rsp_type rsp_d;

   assign fire      = req.valid && req.ready;
   assign req.ready = rdy;
   assign rsp.payload = rsp_d;

   pds_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(fire), .rsp_ready(rsp.ready),
      .sts(sts), .cmd(cmd), .req_ready(rdy), .rsp_valid(rsp.valid)
   );

   pds_datapath #(
      .MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT), .MAX_RADIUS(MAX_RADIUS)
   ) u_dp (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .req_data(req.payload), .cmd(cmd), .sts(sts),
      .rsp_data(rsp_d)
   );
endmodule
